@@ design/rpa_pkg.sv @@
// Shared constants for the resampler position advance block.
// Used by rpa_divider and resampler_position_advance_core; no dependencies.
`default_nettype none
package rpa_pkg;
   localparam int POS_W   = 30;
   localparam int REM_W   = 32;
   localparam int STEP_W  = 24;
   localparam int FLEN_W  = 20;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_REMAINDER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DENOMINATOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_LENGTH    = 2'd3;
endpackage
`default_nettype wire

@@ design/rpa_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rpa_pkg for the divisor width.
`default_nettype none
module rpa_divider #(
   parameter int DW = 49
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DW-1:0]             dividend,
   input  wire logic [rpa_pkg::REM_W-1:0] divisor,
   output logic                           done,
   output logic [DW-1:0]                  quotient,
   output logic [rpa_pkg::REM_W-1:0]      remainder
);
   localparam int RW = rpa_pkg::REM_W;
   localparam int CW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [RW-1:0]   dsr_ff, dsr_in;
   logic [RW:0]     trial;
   logic [RW:0]     diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so one extra bit suffices.
         if (!diff[RW]) begin
            rem_in = diff[RW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[RW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

@@ design/resampler_position_advance_core.sv @@
// Top level of the resampler position advance block.
// Depends on rpa_pkg and rpa_divider.
//
// Each item on the req_ channel describes one mix call: source frame count,
// fixed-point source position, destination frame count and offset, and the
// rational position remainder. One result item leaves on the rsp_ channel:
// new position, new offset, new remainder and source frames consumed.
// The csr_ port writes step size, remainder step, denominator and filter
// length; writes land at the clock edge where csr_we is high.
// One item is worked on at a time; req_tready is high only while idle.
// One shared bit-serial divider does both divisions. An item with nothing
// to mix skips the divider; with no rational step it uses the divider once,
// with a rational step twice, and then rolls back the overshooting steps,
// one per cycle. The divider width DW is 49 with default parameters.
// A finished item waits in the output register, and the next item is
// accepted meanwhile; a stalled receiver holds that register and only
// blocks finishing of the following item. Reset is synchronous and clears
// the sequencer, the output valid and the configuration registers to their reset values.
`default_nettype none
module resampler_position_advance_core #(
   parameter int FRAC_BITS        = 13,
   parameter int FRAME_COUNT_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // source count, source position, destination count, destination offset,
   // position remainder
   input  wire logic [((3*FRAME_COUNT_BITS+62+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // new position, new offset, new remainder, frames consumed
   output logic [((2*FRAME_COUNT_BITS+63+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [rpa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [rpa_pkg::CSR_W-1:0]            csr_wdata
);
   localparam int FB   = FRAME_COUNT_BITS;
   localparam int PSW  = rpa_pkg::POS_W;
   localparam int RW   = rpa_pkg::REM_W;
   localparam int SW   = rpa_pkg::STEP_W;
   localparam int LW   = rpa_pkg::FLEN_W;
   localparam int OUT_W = ((2*FB+63+7)/8)*8;
   localparam int CNW  = FB + 1;
   localparam int PW   = ((FB + FRAC_BITS > 34) ? FB + FRAC_BITS : 34) + 3;
   localparam int DW   = (PW > FB + 33) ? PW : FB + 33;

   localparam int I_POS = FB;
   localparam int I_DC  = FB + PSW;
   localparam int I_DO  = 2*FB + PSW;
   localparam int I_REM = 3*FB + PSW;
   localparam int O_OFF = PSW;
   localparam int O_REM = PSW + FB;
   localparam int O_CON = PSW + FB + RW;

   localparam logic signed [PW-1:0] POS_MAX = PW'((64'sd1 <<< (PSW-1)) - 64'sd1);
   localparam logic signed [PW-1:0] POS_MIN = PW'(-(64'sd1 <<< (PSW-1)));
   localparam logic [CNW-1:0]       CON_MAX = '1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV1 = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV2 = 3'd3;
   localparam logic [2:0] ST_ROLL = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   // Configuration registers.
   logic [SW-1:0] step_ff;
   logic [RW-1:0] step_rem_ff;
   logic [RW-1:0] step_den_ff;
   logic [LW-1:0] flen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= SW'(8192);
         step_rem_ff  <= '0;
         step_den_ff  <= RW'(1);
         flen_ff      <= LW'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            rpa_pkg::CSR_STEP_SIZE:        step_ff      <= csr_wdata[SW-1:0];
            rpa_pkg::CSR_STEP_REMAINDER:   step_rem_ff  <= csr_wdata[RW-1:0];
            rpa_pkg::CSR_STEP_DENOMINATOR: step_den_ff  <= csr_wdata[RW-1:0];
            rpa_pkg::CSR_FILTER_LENGTH:    flen_ff      <= csr_wdata[LW-1:0];
         endcase
      end
   end

   logic [SW-1:0] step_eff;
   logic [RW-1:0] den_eff;
   logic [RW-1:0] smod_eff;
   logic signed [PW-1:0] step_s;
   logic signed [PW-1:0] flen_s;

   always_comb begin
      step_eff = (step_ff == '0) ? SW'(1) : step_ff;
      den_eff  = (step_den_ff == '0) ? RW'(1) : step_den_ff;
      smod_eff = (step_rem_ff < den_eff) ? step_rem_ff : '0;
      step_s   = $signed(PW'(step_eff));
      flen_s   = $signed(PW'(flen_ff));
   end

   // Input fields.
   logic [FB-1:0]         in_src;
   logic signed [PSW-1:0] in_pos;
   logic [FB-1:0]         in_dc;
   logic [FB-1:0]         in_do;
   logic [RW-1:0]         in_rem;
   logic signed [PW-1:0]  in_pos_s;
   logic signed [PW-1:0]  in_end_s;
   logic                  in_mix;

   always_comb begin
      in_src   = req_tdata[FB-1:0];
      in_pos   = $signed(req_tdata[I_DC-1:I_POS]);
      in_dc    = req_tdata[I_DO-1:I_DC];
      in_do    = req_tdata[I_REM-1:I_DO];
      in_rem   = req_tdata[I_REM+RW-1:I_REM];
      in_pos_s = PW'(in_pos);
      in_end_s = $signed(PW'(in_src) << FRAC_BITS) - flen_s + $signed(PW'(1));
      in_mix   = (in_do < in_dc) && (in_pos_s < in_end_s);
   end

   // Sequencer and working registers.
   logic [2:0]           state_ff, state_in;
   logic signed [PW-1:0] pos_ff, pos_in;
   logic signed [PW-1:0] pos0_ff, pos0_in;
   logic signed [PW-1:0] end_ff, end_in;
   logic [FB-1:0]        off_ff, off_in;
   logic [FB-1:0]        space_ff, space_in;
   logic [FB-1:0]        avail_ff, avail_in;
   logic [RW-1:0]        pmod_ff, pmod_in;
   logic                 mix_ff, mix_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 div_start;
   logic [DW-1:0]        div_dividend;
   logic [RW-1:0]        div_divisor;
   logic                 div_done;
   logic [DW-1:0]        div_quo;
   logic [RW-1:0]        div_rem;

   rpa_divider #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   logic [DW:0]          est;
   logic [FB+SW-1:0]     adv_prod;
   logic [FB+RW-1:0]     rem_prod;
   logic                 roll_lt;
   logic signed [PW-1:0] prev_pos;
   logic [RW:0]          pmod_wide;
   logic signed [PW-1:0] after_fr;
   logic signed [PW-1:0] before_fr;
   logic signed [PW-1:0] con_diff;
   logic [CNW-1:0]       con_out;
   logic signed [PW-1:0] pos_sat;
   logic                 out_free;

   always_comb begin
      est       = {1'b0, div_quo} + (DW+1)'(1);
      adv_prod  = avail_ff * step_eff;
      rem_prod  = avail_ff * smod_eff;
      roll_lt   = pmod_ff < smod_eff;
      prev_pos  = pos_ff - step_s - $signed(PW'(roll_lt));
      pmod_wide = roll_lt ? ({1'b0, pmod_ff} + {1'b0, den_eff} - {1'b0, smod_eff})
                          : ({1'b0, pmod_ff} - {1'b0, smod_eff});
      // Arithmetic shift rounds negative frame positions toward minus infinity.
      after_fr  = (pos_ff + flen_s - $signed(PW'(1))) >>> FRAC_BITS;
      before_fr = (pos0_ff + flen_s - $signed(PW'(1))) >>> FRAC_BITS;
      con_diff  = after_fr - before_fr;
      if (!mix_ff || con_diff < $signed(PW'(0)))
         con_out = '0;
      else if (con_diff > $signed(PW'(CON_MAX)))
         con_out = CON_MAX;
      else
         con_out = con_diff[CNW-1:0];
      if (pos_ff > POS_MAX)
         pos_sat = POS_MAX;
      else if (pos_ff < POS_MIN)
         pos_sat = POS_MIN;
      else
         pos_sat = pos_ff;
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      pos0_in      = pos0_ff;
      end_in       = end_ff;
      off_in       = off_ff;
      space_in     = space_ff;
      avail_in     = avail_ff;
      pmod_in      = pmod_ff;
      mix_in       = mix_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = DW'(in_end_s - in_pos_s - $signed(PW'(1)));
      div_divisor  = RW'(step_eff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pos_in   = in_pos_s;
               pos0_in  = in_pos_s;
               end_in   = in_end_s;
               off_in   = in_do;
               space_in = in_dc - in_do;
               pmod_in  = in_rem;
               mix_in   = in_mix;
               if (in_mix) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV1;
               end else begin
                  state_in  = ST_FIN;
               end
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               avail_in = (est < (DW+1)'(space_ff)) ? est[FB-1:0] : space_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            pos_in = pos_ff + $signed(PW'(adv_prod));
            off_in = off_ff + avail_ff;
            div_dividend = DW'(pmod_ff) + DW'(rem_prod);
            div_divisor  = den_eff;
            if (smod_eff != '0) begin
               div_start = 1'b1;
               state_in  = ST_DIV2;
            end else begin
               state_in  = ST_FIN;
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               pos_in   = pos_ff + $signed(PW'(div_quo));
               pmod_in  = div_rem;
               state_in = ST_ROLL;
            end
         end
         ST_ROLL: begin
            // Step back while the previous step still lands at or past the end.
            if (prev_pos >= end_ff) begin
               pos_in  = prev_pos;
               pmod_in = pmod_wide[RW-1:0];
               off_in  = off_ff - FB'(1);
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[PSW-1:0]       = pos_sat[PSW-1:0];
               rsp_data_in[O_REM-1:O_OFF] = off_ff;
               rsp_data_in[O_CON-1:O_REM] = pmod_ff;
               rsp_data_in[O_CON+CNW-1:O_CON] = con_out;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      pos0_ff     <= pos0_in;
      end_ff      <= end_in;
      off_ff      <= off_in;
      space_ff    <= space_in;
      avail_ff    <= avail_in;
      pmod_ff     <= pmod_in;
      mix_ff      <= mix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire
